FILE: hw/rtl/rsu_pkg.sv
// Shared types, constants and conversion functions for the RTC snapshot converter.
package rsu_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTURY_PRESENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_YEAR        = 1'b1;

    // Reset values of the configuration registers.
    localparam logic        RST_CENTURY_PRESENT = 1'b0;
    localparam logic [13:0] RST_REF_YEAR        = 14'd2024;
    localparam logic [7:0]  RST_REF_CENT        = 8'd20;

    // Calendar constants.
    localparam logic [14:0] EPOCH_YEAR         = 15'd1970;
    localparam logic [23:0] LEAPS_BEFORE_EPOCH = 24'd477;
    localparam logic [16:0] SEC_PER_DAY        = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR       = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN        = 6'd60;
    localparam int          HOUR_PM_BIT        = 7;

    // Days elapsed before the first of each month, indexed by months done.
    localparam logic [8:0] CUM_DAYS [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Live configuration seen by the datapath.
    typedef struct packed {
        logic        cen_present;
        logic [13:0] cur_year;
        logic [7:0]  cur_cent;
    } t_cfg;

    // Decoded fields with the full year and the time of day in seconds.
    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hr;
        logic [7:0]  day;
        logic [7:0]  mon;
        logic [14:0] year;
        logic [19:0] tod;
    } t_cal;

    // Decoded fields with the day count since the epoch plus one.
    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hr;
        logic [7:0]  day;
        logic [7:0]  mon;
        logic [14:0] year;
        logic [19:0] tod;
        logic [23:0] days;
    } t_day;

    // Two BCD digits to binary; nibbles above nine are taken as they are.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'b0, v[7:4]};
        return {4'b0, v[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // Hour byte from BCD, tens from bits 6..4, PM flag kept in bit 7.
    function automatic logic [7:0] bcd_hour(input logic [7:0] v);
        logic [6:0] hi;
        logic [6:0] lo;
        hi = {4'b0, v[6:4]};
        lo = {3'b0, v[3:0]} + (hi << 3) + (hi << 1);
        return {v[HOUR_PM_BIT], lo};
    endfunction

    // PM hour to 24-hour form: ((h & 0x7F) + 12) mod 24 by three trial subtracts.
    function automatic logic [7:0] hour_fold(input logic [7:0] h);
        logic [7:0] x;
        x = {1'b0, h[6:0]} + 8'd12;
        if (x >= 8'd96) x = x - 8'd96;
        if (x >= 8'd48) x = x - 8'd48;
        if (x >= 8'd24) x = x - 8'd24;
        return x;
    endfunction

    // Floor of v / 100 as (v / 4) / 25 through a reciprocal, exact for 15-bit v.
    function automatic logic [8:0] div100(input logic [14:0] v);
        logic [25:0] p;
        p = {13'b0, v[14:2]} * 26'd5243;
        return p[25:17];
    endfunction

endpackage

FILE: hw/rtl/rtc_snapshot_to_unix_time_core.sv
// A snapshot taken at a start edge moves through r_s1, r_s2, r_s3, r_s4 and r_done and
// is then strobed on o_done; the result is taken at the edge that ends the strobe.
// Throughput: one snapshot per cycle; o_busy stays low and results cannot be held off.
// The five stages are decode, year, century quotients, day count and the seconds multiply.
// Synchronous active-low reset empties the pipeline, clears the century flag and sets
// the reference year to 2024; the configuration port takes a transfer in every cycle.
module rtc_snapshot_to_unix_time_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [7:0]                     i_raw_second,
    input  logic [7:0]                     i_raw_minute,
    input  logic [7:0]                     i_raw_hour,
    input  logic [7:0]                     i_raw_day,
    input  logic [7:0]                     i_raw_month,
    input  logic [7:0]                     i_raw_year,
    input  logic [7:0]                     i_raw_century,
    input  logic                           i_binary_mode,
    input  logic                           i_hour_24_mode,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rsu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_done,
    output logic [31:0]                    o_unix_time,
    output logic [7:0]                     o_out_second,
    output logic [7:0]                     o_out_minute,
    output logic [7:0]                     o_out_hour,
    output logic [7:0]                     o_out_day,
    output logic [7:0]                     o_out_month,
    output logic [14:0]                    o_full_year
);
    import rsu_pkg::*;

    t_cfg        cfg;
    logic        cal_vld;
    t_cal        cal;
    logic        day_vld;
    t_day        day;
    logic [40:0] day_secs;
    logic [31:0] n_unix;
    logic        r_done;
    logic [31:0] r_unix;
    t_day        r_out;

    // The pipeline never stalls.
    assign o_busy = 1'b0;

    rsu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_start && !o_busy),
        .i_raw_second   (i_raw_second),
        .i_raw_minute   (i_raw_minute),
        .i_raw_hour     (i_raw_hour),
        .i_raw_day      (i_raw_day),
        .i_raw_month    (i_raw_month),
        .i_raw_year     (i_raw_year),
        .i_raw_century  (i_raw_century),
        .i_binary_mode  (i_binary_mode),
        .i_hour_24_mode (i_hour_24_mode),
        .i_cfg          (cfg),
        .o_valid        (cal_vld),
        .o_cal          (cal)
    );

    rsu_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cal_vld),
        .i_cal   (cal),
        .o_valid (day_vld),
        .o_day   (day)
    );

    // Final stage: seconds of whole days plus time of day, less one day, modulo 2^32.
    always_comb begin
        day_secs = {17'b0, day.days} * {24'b0, SEC_PER_DAY};
        n_unix   = day_secs[31:0] + {12'b0, day.tod} - {15'b0, SEC_PER_DAY};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= day_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unix <= n_unix;
        r_out  <= day;
    end

    assign o_done       = r_done;
    assign o_unix_time  = r_unix;
    assign o_out_second = r_out.sec;
    assign o_out_minute = r_out.min;
    assign o_out_hour   = r_out.hr;
    assign o_out_day    = r_out.day;
    assign o_out_month  = r_out.mon;
    assign o_full_year  = r_out.year;

endmodule

FILE: hw/rtl/rsu_cfg.sv
// Configuration registers and the derived century of the reference year.
module rsu_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rsu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rsu_pkg::t_cfg                o_cfg
);
    import rsu_pkg::*;

    logic        r_cen_present;
    logic [13:0] r_cur_year;
    logic [7:0]  r_cur_cent;
    logic [8:0]  n_cur_cent;

    // The register file takes a transfer in every cycle.
    assign o_cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen_present <= RST_CENTURY_PRESENT;
            r_cur_year    <= RST_REF_YEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CENTURY_PRESENT: r_cen_present <= i_cfg_data[0];
                CFG_REF_YEAR:        r_cur_year    <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Century of the reference year, registered from the reference year register.
    assign n_cur_cent = div100({1'b0, r_cur_year});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cent <= RST_REF_CENT;
        end else begin
            r_cur_cent <= n_cur_cent[7:0];
        end
    end

    assign o_cfg = '{cen_present: r_cen_present, cur_year: r_cur_year, cur_cent: r_cur_cent};

endmodule

FILE: hw/rtl/rsu_decode.sv
// Front stages: BCD decode and hour fold, then full year and time of day.
module rsu_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_raw_second,
    input  logic [7:0]    i_raw_minute,
    input  logic [7:0]    i_raw_hour,
    input  logic [7:0]    i_raw_day,
    input  logic [7:0]    i_raw_month,
    input  logic [7:0]    i_raw_year,
    input  logic [7:0]    i_raw_century,
    input  logic          i_binary_mode,
    input  logic          i_hour_24_mode,
    input  rsu_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output rsu_pkg::t_cal o_cal
);
    import rsu_pkg::*;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hr;
        logic [7:0] day;
        logic [7:0] mon;
        logic [7:0] yr;
        logic [7:0] cen;
    } t_dec;

    t_dec        n_s1;
    t_dec        r_s1;
    logic        r_s1_vld;
    t_cal        n_s2;
    t_cal        r_s2;
    logic        r_s2_vld;
    logic [7:0]  hr_dec;
    logic [14:0] year_cen;
    logic [14:0] year_ref;

    // Stage 1 input: decode each byte unless the clock runs in binary mode.
    always_comb begin
        if (i_binary_mode) begin
            n_s1 = '{sec: i_raw_second, min: i_raw_minute, hr: i_raw_hour,
                     day: i_raw_day, mon: i_raw_month, yr: i_raw_year,
                     cen: i_raw_century};
        end else begin
            n_s1 = '{sec: bcd_to_bin(i_raw_second), min: bcd_to_bin(i_raw_minute),
                     hr: bcd_hour(i_raw_hour), day: bcd_to_bin(i_raw_day),
                     mon: bcd_to_bin(i_raw_month), yr: bcd_to_bin(i_raw_year),
                     cen: bcd_to_bin(i_raw_century)};
        end
        hr_dec = n_s1.hr;
        if (!i_hour_24_mode && hr_dec[HOUR_PM_BIT]) begin
            n_s1.hr = hour_fold(hr_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // Stage 2 input: full year from the century byte or the reference year.
    always_comb begin
        year_cen = {7'b0, r_s1.yr} + {7'b0, r_s1.cen} * 15'd100;
        year_ref = {7'b0, r_s1.yr} + {7'b0, i_cfg.cur_cent} * 15'd100;
        if (year_ref < {1'b0, i_cfg.cur_year}) begin
            year_ref = year_ref + 15'd100;
        end
        n_s2.sec  = r_s1.sec;
        n_s2.min  = r_s1.min;
        n_s2.hr   = r_s1.hr;
        n_s2.day  = r_s1.day;
        n_s2.mon  = r_s1.mon;
        n_s2.year = i_cfg.cen_present ? year_cen : year_ref;
        n_s2.tod  = {12'b0, r_s1.hr} * {8'b0, SEC_PER_HOUR}
                  + {12'b0, r_s1.min} * {14'b0, SEC_PER_MIN}
                  + {12'b0, r_s1.sec};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_s2_vld;
    assign o_cal   = r_s2;

endmodule

FILE: hw/rtl/rsu_days.sv
// Middle stages: century quotients, then the day count since the epoch.
module rsu_days (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rsu_pkg::t_cal i_cal,
    output logic          o_valid,
    output rsu_pkg::t_day o_day
);
    import rsu_pkg::*;

    typedef struct packed {
        t_cal        cal;
        logic [12:0] n_div4;
        logic [8:0]  q_n;
        logic [8:0]  q_y;
        logic        after_epoch;
    } t_quo;

    t_quo        n_s3;
    t_quo        r_s3;
    logic        r_s3_vld;
    t_day        n_s4;
    t_day        r_s4;
    logic        r_s4_vld;
    logic [14:0] prev_year;
    logic        leap;
    logic [23:0] year_days;
    logic [12:0] mon_days;
    logic [3:0]  mon_done;

    // Stage 3 input: quotients by one hundred of the year and the year before.
    always_comb begin
        prev_year          = i_cal.year - 15'd1;
        n_s3.cal           = i_cal;
        n_s3.n_div4        = prev_year[14:2];
        n_s3.q_n           = div100(prev_year);
        n_s3.q_y           = div100(i_cal.year);
        n_s3.after_epoch   = (i_cal.year > EPOCH_YEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= n_s3;
    end

    // Stage 4 input: Gregorian year days, month days and the day of month.
    always_comb begin
        leap = (r_s3.cal.year[1:0] == 2'b00)
            && (({1'b0, r_s3.cal.year} != {7'b0, r_s3.q_y} * 16'd100)
                || (r_s3.q_y[1:0] == 2'b00));

        if (r_s3.after_epoch) begin
            year_days = 24'(r_s3.cal.year - EPOCH_YEAR) * 24'd365
                      + {11'b0, r_s3.n_div4} - {15'b0, r_s3.q_n}
                      + {17'b0, r_s3.q_n[8:2]} - LEAPS_BEFORE_EPOCH;
        end else begin
            year_days = '0;
        end

        // Months past December count 31 days each.
        mon_done = r_s3.cal.mon[3:0] - 4'd1;
        if (r_s3.cal.mon <= 8'd1) begin
            mon_days = '0;
        end else if (r_s3.cal.mon <= 8'd13) begin
            mon_days = {4'b0, CUM_DAYS[mon_done]}
                     + {12'b0, (leap && (r_s3.cal.mon >= 8'd3))};
        end else begin
            mon_days = 13'd365 + {12'b0, leap}
                     + {5'b0, r_s3.cal.mon - 8'd13} * 13'd31;
        end

        n_s4.sec  = r_s3.cal.sec;
        n_s4.min  = r_s3.cal.min;
        n_s4.hr   = r_s3.cal.hr;
        n_s4.day  = r_s3.cal.day;
        n_s4.mon  = r_s3.cal.mon;
        n_s4.year = r_s3.cal.year;
        n_s4.tod  = r_s3.cal.tod;
        n_s4.days = year_days + {11'b0, mon_days} + {16'b0, r_s3.cal.day};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= n_s4;
    end

    assign o_valid = r_s4_vld;
    assign o_day   = r_s4;

endmodule

FILE: hw/rtl/rsu_checker.sv
// Port-level checks on the converter and the bind that attaches them.
module rsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [7:0]  i_raw_second,
    input logic [7:0]  i_raw_hour,
    input logic        i_binary_mode,
    input logic        i_hour_24_mode,
    input logic        o_done,
    input logic [7:0]  o_out_second,
    input logic [7:0]  o_out_hour
);

    // Every accepted snapshot gives a result at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_done)
        else $error("result missing five cycles after a start transfer");

    // No result appears without a matching accepted snapshot.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##5 !o_done)
        else $error("result without a matching start transfer");

    // In binary mode the seconds byte passes through unchanged.
    a_binary_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_binary_mode) |-> ##5 (o_out_second == $past(i_raw_second, 5)))
        else $error("binary seconds not passed through");

    // A PM hour in 12-hour mode always folds into the 24-hour range.
    a_pm_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_hour_24_mode && i_raw_hour[7]) |-> ##5 (o_out_hour < 8'd24))
        else $error("PM hour not folded into 24-hour form");

endmodule

bind rtc_snapshot_to_unix_time_core rsu_checker u_rsu_checker (.*);

FILE: sim/rtc_snapshot_to_unix_time_core_tb.sv
// Self-checking testbench for the RTC snapshot to Unix time converter.
module rtc_snapshot_to_unix_time_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsu_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int SHOW_LIMIT   = 10;
    localparam int SETTLE_CYCLES = 10;
    localparam logic [31:0] FIRST_YEAR = 32'd1970;
    localparam logic [31:0] MONTH_START [13] = '{
        32'd0, 32'd31, 32'd59, 32'd90, 32'd120, 32'd151, 32'd181,
        32'd212, 32'd243, 32'd273, 32'd304, 32'd334, 32'd365
    };

    // One raw register snapshot as it goes into the block.
    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic       binary_mode;
        logic       hour_24;
    } t_rtc_snap;

    // One converted result, in the order of the output ports.
    typedef struct packed {
        logic [31:0] unix_time;
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [14:0] full_year;
    } t_rtc_result;

    // Keeps a copy of the configuration and the conversions still awaited.
    class t_conversion_scoreboard;
        bit          century_on;
        logic [13:0] ref_year;
        t_rtc_result awaited_conversions[$];
        int unsigned mismatches;

        function new();
            century_on = RST_CENTURY_PRESENT;
            ref_year   = RST_REF_YEAR;
            mismatches = 0;
        endfunction

        function logic [31:0] bcd_value(logic [31:0] v);
            return ((v & 32'h0F) + (v >> 4) * 32'd10) & 32'hFF;
        endfunction

        function logic [31:0] leaps_through(logic [31:0] n);
            return n / 32'd4 - n / 32'd100 + n / 32'd400;
        endfunction

        function bit is_leap(logic [31:0] y);
            return (y % 32'd4 == 0) && ((y % 32'd100 != 0) || (y % 32'd400 == 0));
        endfunction

        // Decodes the snapshot and counts seconds since 1970, all modulo 2^32.
        function t_rtc_result convert_snapshot(t_rtc_snap s);
            logic [31:0] sec, mins, hr, dd, mm, yy, cc;
            logic [31:0] year, days, elapsed, ts;
            t_rtc_result r;
            sec  = {24'b0, s.second};
            mins = {24'b0, s.minute};
            hr   = {24'b0, s.hour};
            dd   = {24'b0, s.day};
            mm   = {24'b0, s.month};
            yy   = {24'b0, s.year};
            cc   = {24'b0, s.century};
            if (!s.binary_mode) begin
                sec  = bcd_value(sec);
                mins = bcd_value(mins);
                hr   = ((hr & 32'h0F) + ((hr & 32'h70) >> 4) * 32'd10) | (hr & 32'h80);
                dd   = bcd_value(dd);
                mm   = bcd_value(mm);
                yy   = bcd_value(yy);
                cc   = bcd_value(cc);
            end
            // A PM hour folds to 24-hour form only on a 12-hour clock.
            if (!s.hour_24 && hr[7])
                hr = ((hr & 32'h7F) + 32'd12) % 32'd24;
            if (century_on) begin
                year = yy + cc * 32'd100;
            end else begin
                year = yy + ({18'b0, ref_year} / 32'd100) * 32'd100;
                if (year < {18'b0, ref_year})
                    year = year + 32'd100;
            end
            days = 32'd0;
            if (year > FIRST_YEAR)
                days = 32'd365 * (year - FIRST_YEAR) + leaps_through(year - 32'd1)
                     - leaps_through(FIRST_YEAR - 32'd1);
            // Months past December count 31 days each.
            if (mm > 32'd1) begin
                elapsed = mm - 32'd1;
                if (elapsed <= 32'd12) begin
                    days = days + MONTH_START[elapsed];
                    if (elapsed >= 32'd2 && is_leap(year))
                        days = days + 32'd1;
                end else begin
                    days = days + MONTH_START[12] + (is_leap(year) ? 32'd1 : 32'd0)
                         + 32'd31 * (elapsed - 32'd12);
                end
            end
            days = days + dd - 32'd1;
            ts = days * 32'd86400 + hr * 32'd3600 + mins * 32'd60 + sec;
            r.unix_time = ts;
            r.second    = sec[7:0];
            r.minute    = mins[7:0];
            r.hour      = hr[7:0];
            r.day       = dd[7:0];
            r.month     = mm[7:0];
            r.full_year = year[14:0];
            return r;
        endfunction

        function void note_snapshot(t_rtc_snap s);
            awaited_conversions.push_back(convert_snapshot(s));
        endfunction

        function void check_result(t_rtc_result got);
            t_rtc_result want;
            if (awaited_conversions.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: time=%0d y=%0d", got.unix_time, got.full_year);
                return;
            end
            want = awaited_conversions.pop_front();
            if (got.unix_time !== want.unix_time || got.second !== want.second ||
                    got.minute !== want.minute || got.hour !== want.hour ||
                    got.day !== want.day || got.month !== want.month ||
                    got.full_year !== want.full_year) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("mismatch expected: time=%0d %0d-%0d-%0d %0d:%0d:%0d",
                             want.unix_time, want.full_year, want.month, want.day,
                             want.hour, want.minute, want.second);
                    $display("mismatch actual:   time=%0d %0d-%0d-%0d %0d:%0d:%0d",
                             got.unix_time, got.full_year, got.month, got.day,
                             got.hour, got.minute, got.second);
                end
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_start        = 1'b0;
    logic [7:0]            i_raw_second   = '0;
    logic [7:0]            i_raw_minute   = '0;
    logic [7:0]            i_raw_hour     = '0;
    logic [7:0]            i_raw_day      = '0;
    logic [7:0]            i_raw_month    = '0;
    logic [7:0]            i_raw_year     = '0;
    logic [7:0]            i_raw_century  = '0;
    logic                  i_binary_mode  = 1'b0;
    logic                  i_hour_24_mode = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_busy;
    logic                  o_cfg_ready;
    logic                  o_done;
    logic [31:0]           o_unix_time;
    logic [7:0]            o_out_second;
    logic [7:0]            o_out_minute;
    logic [7:0]            o_out_hour;
    logic [7:0]            o_out_day;
    logic [7:0]            o_out_month;
    logic [14:0]           o_full_year;

    t_conversion_scoreboard sb;
    bit                     no_gaps = 1'b0;
    int unsigned            cycle_count = 0;

    rtc_snapshot_to_unix_time_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_raw_second   (i_raw_second),
        .i_raw_minute   (i_raw_minute),
        .i_raw_hour     (i_raw_hour),
        .i_raw_day      (i_raw_day),
        .i_raw_month    (i_raw_month),
        .i_raw_year     (i_raw_year),
        .i_raw_century  (i_raw_century),
        .i_binary_mode  (i_binary_mode),
        .i_hour_24_mode (i_hour_24_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_unix_time    (o_unix_time),
        .o_out_second   (o_out_second),
        .o_out_minute   (o_out_minute),
        .o_out_hour     (o_out_hour),
        .o_out_day      (o_out_day),
        .o_out_month    (o_out_month),
        .o_full_year    (o_full_year)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Every strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result({o_unix_time, o_out_second, o_out_minute, o_out_hour,
                             o_out_day, o_out_month, o_full_year});
    end

    function automatic t_rtc_snap snap(logic [7:0] sec, logic [7:0] mins, logic [7:0] hr,
                                       logic [7:0] dd, logic [7:0] mm, logic [7:0] yy,
                                       logic [7:0] cc, logic bm, logic h24);
        return '{sec, mins, hr, dd, mm, yy, cc, bm, h24};
    endfunction

    // Encodes a binary value the way the clock stores it in the chosen mode.
    function automatic logic [7:0] encode(int unsigned v, logic bm);
        return bm ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Random bits in every field.
    function automatic t_rtc_snap noise_snapshot();
        return t_rtc_snap'({$urandom, 26'($urandom)});
    endfunction

    // Mostly plausible calendar snapshots with random content, the rest raw noise.
    function automatic t_rtc_snap random_snapshot();
        t_rtc_snap s;
        logic      bm;
        logic      h24;
        logic      pm;
        if ($urandom_range(0, 99) < 30)
            return noise_snapshot();
        bm  = 1'($urandom);
        h24 = 1'($urandom);
        pm  = 1'($urandom);
        s.binary_mode = bm;
        s.hour_24     = h24;
        s.second      = encode($urandom_range(0, 59), bm);
        s.minute      = encode($urandom_range(0, 59), bm);
        if (h24)
            s.hour = encode($urandom_range(0, 23), bm);
        else
            s.hour = encode($urandom_range(1, 12), bm) | {pm, 7'b0};
        s.day     = encode($urandom_range(1, 31), bm);
        s.month   = encode($urandom_range(1, 12), bm);
        s.year    = encode($urandom_range(0, 99), bm);
        s.century = encode(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                       : $urandom_range(19, 21), bm);
        return s;
    endfunction

    task automatic put_fields(t_rtc_snap s);
        i_raw_second   <= s.second;
        i_raw_minute   <= s.minute;
        i_raw_hour     <= s.hour;
        i_raw_day      <= s.day;
        i_raw_month    <= s.month;
        i_raw_year     <= s.year;
        i_raw_century  <= s.century;
        i_binary_mode  <= s.binary_mode;
        i_hour_24_mode <= s.hour_24;
    endtask

    // Holds start low with junk on the fields while the sender idles.
    task automatic pause(int unsigned n);
        i_start <= 1'b0;
        put_fields(noise_snapshot());
        repeat (n) @(posedge i_clk);
    endtask

    // Offers one snapshot until it is transferred, then maybe idles.
    task automatic push_snapshot(t_rtc_snap s);
        put_fields(s);
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_snapshot(s);
        if (!no_gaps && $urandom_range(0, 99) < 29)
            pause($urandom_range(1, 8));
    endtask

    // Stops the sender until every awaited conversion has come back.
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_conversions.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_CENTURY_PRESENT)
            sb.century_on = data[0];
        else
            sb.ref_year = data;
    endtask

    // Writes both registers back to back; only called with the pipeline empty.
    task automatic set_config(logic cen_on, logic [13:0] cur_year);
        cfg_write(CFG_CENTURY_PRESENT, {13'b0, cen_on});
        cfg_write(CFG_REF_YEAR, cur_year);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // Inferred century from the reset year.
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        push_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
        push_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        push_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24, 8'h00, 1'b0, 1'b1));
        // Midnight and noon on a 12-hour clock.
        push_snapshot(snap(8'h00, 8'h30, 8'h12, 8'h15, 8'h06, 8'h25, 8'h00, 1'b0, 1'b0));
        push_snapshot(snap(8'h00, 8'h30, 8'h92, 8'h15, 8'h06, 8'h25, 8'h00, 1'b0, 1'b0));
        // PM bit left set on a 24-hour clock.
        push_snapshot(snap(8'h01, 8'h02, 8'h85, 8'h10, 8'h10, 8'h30, 8'h00, 1'b0, 1'b1));
        // Nibbles above nine.
        push_snapshot(snap(8'hAF, 8'h9A, 8'h3C, 8'h1F, 8'h0B, 8'hE7, 8'h00, 1'b0, 1'b1));
        // Months past December, then month zero with day zero.
        push_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h01, 8'h13, 8'h24, 8'h00, 1'b0, 1'b1));
        push_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h05, 8'h25, 8'h28, 8'h00, 1'b0, 1'b1));
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h24, 8'h00, 1'b0, 1'b1));
        // Two-digit year before the reference year rolls to the next century.
        push_snapshot(snap(8'h45, 8'h15, 8'h08, 8'h04, 8'h07, 8'h23, 8'h00, 1'b0, 1'b1));
        push_snapshot(snap(8'd59, 8'd59, 8'h8B, 8'd31, 8'd12, 8'd25, 8'd0, 1'b1, 1'b0));
        drain();
        // Century byte in use, lowest reference year.
        set_config(1'b1, 14'd1970);
        push_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19, 1'b0, 1'b1));
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19, 1'b0, 1'b1));
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20, 1'b0, 1'b1));
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21, 1'b0, 1'b1));
        push_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
        push_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        // First second after the 32-bit count wraps.
        push_snapshot(snap(8'h16, 8'h28, 8'h06, 8'h07, 8'h02, 8'h06, 8'h21, 1'b0, 1'b1));
    endtask

    // Main sequence: reset, directed snapshots, then random phases.
    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < 7; phase++) begin
            drain();
            case (phase)
                0: set_config(1'b0, 14'd1970);
                1: set_config(1'b0, 14'd9999);
                2: set_config(1'b1, 14'd1970);
                3: set_config(1'b1, 14'd9999);
                4: set_config(1'b0, 14'($urandom_range(1970, 9999)));
                5: set_config(1'b1, 14'($urandom_range(1970, 9999)));
                default: set_config(RST_CENTURY_PRESENT, RST_REF_YEAR);
            endcase
            no_gaps = (phase == 3);
            repeat (75) push_snapshot(random_snapshot());
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited_conversions.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
